// File: rtl/core/rcrls_pkg.sv
package rcrls_pkg;

    localparam int CHANNELS   = 8;
    localparam int TIME_BITS  = 12;
    localparam int CHAN_BITS  = 3;
    localparam int REQ_BITS   = 3;
    localparam int COUNT_BITS = 4;

    localparam logic [TIME_BITS-1:0] RESET_THRESHOLD = TIME_BITS'(700);
    localparam logic [TIME_BITS-1:0] RESET_WAIT      = TIME_BITS'(1024);
    localparam logic [TIME_BITS-1:0] TIME_MAX        = {TIME_BITS{1'b1}};

    typedef enum logic [REQ_BITS-1:0] {
        REQ_TICK      = 3'd0,
        REQ_BEGIN_RD  = 3'd1,
        REQ_BEGIN_CAL = 3'd2,
        REQ_END_CAL   = 3'd3,
        REQ_LOAD_THR  = 3'd4
    } req_t;

    // per-transfer strobes and shared values broadcast to every lane
    typedef struct packed {
        logic                 sample;
        logic                 close;
        logic                 begin_rd;
        logic                 begin_cal;
        logic                 end_cal;
        logic                 calibrating;
        logic [TIME_BITS-1:0] tick;
        logic [TIME_BITS-1:0] wait_limit;
    } lane_ctrl_t;

endpackage

// File: rtl/core/rcrls_lane.sv
module rcrls_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rcrls_pkg::lane_ctrl_t               ctrl,
    input  logic                                pin_level,
    input  logic                                load_en,
    input  logic [rcrls_pkg::TIME_BITS-1:0]     load_value,
    output logic                                above_thr
);

    logic [rcrls_pkg::TIME_BITS-1:0] time_reg, time_next;
    logic                            seen_reg, seen_next;
    logic [rcrls_pkg::TIME_BITS-1:0] hi_reg, hi_next;
    logic [rcrls_pkg::TIME_BITS-1:0] lo_reg, lo_next;
    logic [rcrls_pkg::TIME_BITS-1:0] thr_reg, thr_next;

    logic                            hit;
    logic [rcrls_pkg::TIME_BITS-1:0] time_now;
    logic                            seen_now;
    logic [rcrls_pkg::TIME_BITS-1:0] final_time;
    logic [rcrls_pkg::TIME_BITS:0]   mid_sum;

    // a tick that samples also counts toward the window it closes
    assign hit        = ctrl.sample && !pin_level && !seen_reg;
    assign time_now   = hit ? ctrl.tick : time_reg;
    assign seen_now   = seen_reg | hit;
    assign final_time = seen_now ? time_now : ctrl.wait_limit;
    assign mid_sum    = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign above_thr  = final_time > thr_reg;

    always_comb begin
        time_next = time_now;
        seen_next = seen_now;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        thr_next  = thr_reg;
        if (ctrl.close) begin
            time_next = final_time;
            if (ctrl.calibrating) begin
                if (final_time > hi_reg) begin
                    hi_next = final_time;
                end
                if (final_time < lo_reg) begin
                    lo_next = final_time;
                end
            end
        end
        if (ctrl.begin_rd) begin
            time_next = ctrl.wait_limit;
            seen_next = 1'b0;
        end
        if (ctrl.begin_cal) begin
            hi_next = '0;
            lo_next = ctrl.wait_limit;
        end
        if (ctrl.end_cal) begin
            thr_next = mid_sum[rcrls_pkg::TIME_BITS:1];
        end
        if (load_en) begin
            thr_next = load_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            seen_reg <= 1'b0;
            hi_reg   <= '0;
            lo_reg   <= rcrls_pkg::RESET_WAIT;
            thr_reg  <= rcrls_pkg::RESET_THRESHOLD;
        end else begin
            time_reg <= time_next;
            seen_reg <= seen_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            thr_reg  <= thr_next;
        end
    end

endmodule

// File: rtl/core/rcrls_merge.sv
module rcrls_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 close,
    input  logic [rcrls_pkg::CHANNELS-1:0]       hits,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [rcrls_pkg::CHANNELS-1:0]       m_line_pattern,
    output logic [rcrls_pkg::COUNT_BITS-1:0]     m_high_count
);

    logic                                valid_reg;
    logic [rcrls_pkg::CHANNELS-1:0]      pattern_reg, pattern_next;
    logic [rcrls_pkg::COUNT_BITS-1:0]    count_reg, count_next;

    // channel 0 lands in the MSB
    always_comb begin
        count_next = '0;
        for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
            pattern_next[rcrls_pkg::CHANNELS-1-k] = hits[k];
            count_next = count_next + rcrls_pkg::COUNT_BITS'(hits[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (close) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (close) begin
            pattern_reg <= pattern_next;
            count_reg   <= count_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_line_pattern = pattern_reg;
    assign m_high_count   = count_reg;

endmodule

// File: rtl/core/rc_reflectance_line_sensor_unit.sv
// Eight-channel RC-discharge reflectance front end. One request transfer is taken
// every cycle while the input is not stalled; a sample tick is worked by all channel
// lanes at once, and the tick that closes the window registers its line pattern and
// high-channel count in the output register. Input is stalled only while that output register
// holds a result that the sink has not taken. max_wait is written through the cfg
// channel, which is always ready; write it only while no reading is in progress.
module rc_reflectance_line_sensor_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wvalid,
    output logic                                 cfg_wready,
    input  logic [rcrls_pkg::TIME_BITS-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rcrls_pkg::REQ_BITS-1:0]       s_req_type,
    input  logic [rcrls_pkg::CHANNELS-1:0]       s_pin_levels,
    input  logic [rcrls_pkg::CHAN_BITS-1:0]      s_channel,
    input  logic [rcrls_pkg::TIME_BITS-1:0]      s_threshold_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rcrls_pkg::CHANNELS-1:0]       m_line_pattern,
    output logic [rcrls_pkg::COUNT_BITS-1:0]     m_high_count
);

    logic [rcrls_pkg::TIME_BITS-1:0] max_wait_reg;
    logic [rcrls_pkg::TIME_BITS-1:0] tick_reg, tick_next;
    logic                            measuring_reg, measuring_next;
    logic                            calibrating_reg, calibrating_next;

    logic                            xfer;
    logic                            tick_xfer;
    logic [rcrls_pkg::TIME_BITS-1:0] tick_inc;
    rcrls_pkg::lane_ctrl_t           ctrl;
    logic [rcrls_pkg::CHANNELS-1:0]  hits;

    assign cfg_wready = 1'b1;
    assign s_ready    = !m_valid || m_ready;
    assign xfer       = s_valid && s_ready;
    assign tick_xfer  = xfer && (s_req_type == rcrls_pkg::REQ_TICK) && measuring_reg;
    assign tick_inc   = (tick_reg == rcrls_pkg::TIME_MAX) ? tick_reg : tick_reg + 1'b1;

    always_comb begin
        ctrl             = '0;
        ctrl.tick        = tick_reg;
        ctrl.wait_limit  = max_wait_reg;
        ctrl.calibrating = calibrating_reg;
        ctrl.sample      = tick_xfer && (tick_reg < max_wait_reg);
        ctrl.close       = tick_xfer && (tick_inc >= max_wait_reg);
        ctrl.begin_rd    = xfer && (s_req_type == rcrls_pkg::REQ_BEGIN_RD);
        ctrl.begin_cal   = xfer && (s_req_type == rcrls_pkg::REQ_BEGIN_CAL);
        ctrl.end_cal     = xfer && (s_req_type == rcrls_pkg::REQ_END_CAL) && calibrating_reg;
    end

    always_comb begin
        tick_next        = tick_reg;
        measuring_next   = measuring_reg;
        calibrating_next = calibrating_reg;
        if (tick_xfer) begin
            tick_next = tick_inc;
        end
        if (ctrl.close) begin
            measuring_next = 1'b0;
        end
        if (ctrl.begin_rd) begin
            tick_next      = '0;
            measuring_next = 1'b1;
        end
        if (ctrl.begin_cal) begin
            calibrating_next = 1'b1;
        end
        if (ctrl.end_cal) begin
            calibrating_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_wait_reg    <= rcrls_pkg::RESET_WAIT;
            tick_reg        <= '0;
            measuring_reg   <= 1'b0;
            calibrating_reg <= 1'b0;
        end else begin
            if (cfg_wvalid && cfg_wready) begin
                max_wait_reg <= cfg_wdata;
            end
            tick_reg        <= tick_next;
            measuring_reg   <= measuring_next;
            calibrating_reg <= calibrating_next;
        end
    end

    for (genvar k = 0; k < rcrls_pkg::CHANNELS; k++) begin : g_lane
        logic load_en;
        assign load_en = xfer && (s_req_type == rcrls_pkg::REQ_LOAD_THR)
                         && (int'(s_channel) == k);

        rcrls_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .pin_level  (s_pin_levels[k]),
            .load_en    (load_en),
            .load_value (s_threshold_value),
            .above_thr  (hits[k])
        );
    end

    rcrls_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .close          (ctrl.close),
        .hits           (hits),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_line_pattern (m_line_pattern),
        .m_high_count   (m_high_count)
    );

    a_result_from_close: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && measuring_reg
                                 && s_req_type == rcrls_pkg::REQ_TICK))
        else $error("result appeared without a window-closing tick");

    a_close_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.close |=> m_valid)
        else $error("window closed but no result registered");

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_high_count == rcrls_pkg::COUNT_BITS'($countones(m_line_pattern))))
        else $error("high count disagrees with pattern");

    a_close_ends_reading: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.close && !ctrl.begin_rd) |=> !measuring_reg)
        else $error("reading still active after window close");

endmodule

// File: test/rc_reflectance_line_sensor_unit_test.sv
`timescale 1ns / 1ps

module rc_reflectance_line_sensor_unit_test;

    typedef logic [rcrls_pkg::REQ_BITS-1:0]   code_t;
    typedef logic [rcrls_pkg::CHANNELS-1:0]   pins_t;
    typedef logic [rcrls_pkg::CHAN_BITS-1:0]  chan_t;
    typedef logic [rcrls_pkg::TIME_BITS-1:0]  time_t;
    typedef logic [rcrls_pkg::COUNT_BITS-1:0] count_t;

    typedef struct {
        code_t code;
        pins_t pins;
        chan_t chan;
        time_t level;
    } sensor_request_t;

    typedef struct {
        pins_t  pattern;
        count_t count;
    } line_reading_t;

    logic   aclk;
    logic   aresetn = 1'b0;
    logic   cfg_wvalid = 1'b0;
    logic   cfg_wready;
    time_t  cfg_wdata = '0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    code_t  s_req_type = '0;
    pins_t  s_pin_levels = '0;
    chan_t  s_channel = '0;
    time_t  s_threshold_value = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    pins_t  m_line_pattern;
    count_t m_high_count;

    rc_reflectance_line_sensor_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wvalid        (cfg_wvalid),
        .cfg_wready        (cfg_wready),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_pin_levels      (s_pin_levels),
        .s_channel         (s_channel),
        .s_threshold_value (s_threshold_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_line_pattern    (m_line_pattern),
        .m_high_count      (m_high_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // sensor model state
    time_t max_wait_reg;
    time_t disch_time [rcrls_pkg::CHANNELS];
    logic  went_low   [rcrls_pkg::CHANNELS];
    time_t cal_high   [rcrls_pkg::CHANNELS];
    time_t cal_low    [rcrls_pkg::CHANNELS];
    time_t chan_thr   [rcrls_pkg::CHANNELS];
    time_t tick_count;
    logic  reading_open;
    logic  cal_on;

    sensor_request_t pending_requests [$];
    line_reading_t   expected_lines [$];
    line_reading_t   want;
    sensor_request_t next_req;

    int unsigned offered_items = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen = 0;
    int unsigned results_served = 0;
    int unsigned mismatch_count = 0;
    int unsigned stim_count = 0;
    int unsigned src_wait = 0;
    int unsigned src_calm = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_calm = 0;
    int unsigned sink_hold = 0;
    bit          long_stall_done = 0;

    task automatic apply_request(input code_t code,
                                 input pins_t pins,
                                 input chan_t chan,
                                 input time_t level);
        line_reading_t                 reading;
        logic [rcrls_pkg::TIME_BITS:0] mid_sum;
        case (code)
            rcrls_pkg::REQ_TICK: begin
                if (reading_open) begin
                    if (tick_count < max_wait_reg) begin
                        for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
                            if (!pins[k] && !went_low[k]) begin
                                disch_time[k] = tick_count;
                                went_low[k] = 1'b1;
                            end
                        end
                    end
                    if (tick_count != rcrls_pkg::TIME_MAX)
                        tick_count = tick_count + 1'b1;
                    if (tick_count >= max_wait_reg) begin
                        reading_open = 1'b0;
                        reading.pattern = '0;
                        reading.count = '0;
                        for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
                            if (!went_low[k])
                                disch_time[k] = max_wait_reg;
                            if (cal_on) begin
                                if (disch_time[k] > cal_high[k])
                                    cal_high[k] = disch_time[k];
                                if (disch_time[k] < cal_low[k])
                                    cal_low[k] = disch_time[k];
                            end
                            // channel 0 lands in the MSB
                            reading.pattern = {reading.pattern[rcrls_pkg::CHANNELS-2:0],
                                               disch_time[k] > chan_thr[k]};
                            if (disch_time[k] > chan_thr[k])
                                reading.count = reading.count + 1'b1;
                        end
                        expected_lines.push_back(reading);
                    end
                end
            end
            rcrls_pkg::REQ_BEGIN_RD: begin
                for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
                    disch_time[k] = max_wait_reg;
                    went_low[k] = 1'b0;
                end
                tick_count = '0;
                reading_open = 1'b1;
            end
            rcrls_pkg::REQ_BEGIN_CAL: begin
                for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
                    cal_high[k] = '0;
                    cal_low[k] = max_wait_reg;
                end
                cal_on = 1'b1;
            end
            rcrls_pkg::REQ_END_CAL: begin
                if (cal_on) begin
                    for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
                        mid_sum = cal_high[k] + cal_low[k];
                        chan_thr[k] = mid_sum[rcrls_pkg::TIME_BITS:1];
                    end
                    cal_on = 1'b0;
                end
            end
            rcrls_pkg::REQ_LOAD_THR: begin
                if (chan < rcrls_pkg::CHANNELS)
                    chan_thr[chan] = level;
            end
            default: ;
        endcase
    endtask

    // request side: present queued items, accept tracking at the rising edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || accepted_items == offered_items) begin
                if (src_wait > 0) begin
                    s_valid <= 1'b0;
                    src_wait = src_wait - 1;
                end else if (pending_requests.size() != 0) begin
                    next_req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= next_req.code;
                    s_pin_levels <= next_req.pins;
                    s_channel <= next_req.chan;
                    s_threshold_value <= next_req.level;
                    offered_items <= offered_items + 1;
                    if (src_calm > 0) begin
                        src_calm = src_calm - 1;
                        src_wait = 0;
                    end else begin
                        if ($urandom_range(0, 24) == 0)
                            src_calm = $urandom_range(8, 48);
                        src_wait = $urandom_range(0, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            apply_request(s_req_type, s_pin_levels, s_channel, s_threshold_value);
            accepted_items <= accepted_items + 1;
        end
    end

    // result side
    always @(negedge aclk) begin
        if (aresetn) begin
            if (results_seen != results_served) begin
                results_served = results_seen;
                if (sink_calm > 0) begin
                    sink_calm = sink_calm - 1;
                    sink_wait = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        sink_calm = $urandom_range(5, 25);
                    sink_wait = $urandom_range(0, 12);
                end
                // one long stall so the output register backs up into the input
                if (results_seen == 30 && !long_stall_done) begin
                    sink_hold = 300;
                    long_stall_done = 1;
                end
            end
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else if (sink_wait > 0) begin
                m_ready <= 1'b0;
                sink_wait = sink_wait - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_lines.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual pattern %h count %0d",
                         $time, m_line_pattern, m_high_count);
                mismatch_count++;
            end else begin
                want = expected_lines.pop_front();
                if (m_line_pattern !== want.pattern) begin
                    $display("%0t: line_pattern expected %h actual %h",
                             $time, want.pattern, m_line_pattern);
                    mismatch_count++;
                end
                if (m_high_count !== want.count) begin
                    $display("%0t: high_count expected %0d actual %0d",
                             $time, want.count, m_high_count);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_request(input code_t code,
                                input pins_t pins,
                                input chan_t chan,
                                input time_t level,
                                input bit counted);
        sensor_request_t item;
        item.code = code;
        item.pins = pins;
        item.chan = chan;
        item.level = level;
        pending_requests.push_back(item);
        if (counted)
            stim_count++;
    endtask

    task automatic push_side_request(input int unsigned window, input bit idle);
        int unsigned pick;
        int unsigned top;
        pick = $urandom_range(0, idle ? 5 : 4);
        top = window + 1;
        if (top > 32'(rcrls_pkg::TIME_MAX))
            top = 32'(rcrls_pkg::TIME_MAX);
        case (pick)
            0, 1: push_request(rcrls_pkg::REQ_LOAD_THR, pins_t'($urandom), chan_t'($urandom),
                               ($urandom_range(0, 3) == 0) ? time_t'($urandom)
                                                           : time_t'($urandom_range(0, top)),
                               1);
            2: push_request(rcrls_pkg::REQ_BEGIN_CAL, pins_t'($urandom), chan_t'($urandom),
                            time_t'($urandom), 1);
            3: push_request(rcrls_pkg::REQ_END_CAL, pins_t'($urandom), chan_t'($urandom),
                            time_t'($urandom), 1);
            4: push_request(code_t'($urandom_range(rcrls_pkg::REQ_LOAD_THR + 1,
                                                   (1 << rcrls_pkg::REQ_BITS) - 1)),
                            pins_t'($urandom), chan_t'($urandom), time_t'($urandom), 0);
            default: push_request(rcrls_pkg::REQ_TICK, pins_t'($urandom), chan_t'($urandom),
                                  time_t'($urandom), 0);
        endcase
    endtask

    // one full window: begin, then ticks until it closes; each channel drops at its own tick
    task automatic push_reading(input int unsigned window);
        int unsigned drop_at [rcrls_pkg::CHANNELS];
        int unsigned n;
        bit          scrambled;
        pins_t       pins;
        push_request(rcrls_pkg::REQ_BEGIN_RD, pins_t'($urandom), chan_t'($urandom),
                     time_t'($urandom), 1);
        scrambled = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < rcrls_pkg::CHANNELS; k++)
            drop_at[k] = ($urandom_range(0, 4) == 0) ? window : $urandom_range(0, window);
        n = 0;
        while (n < window) begin
            if ($urandom_range(0, 30) == 0) begin
                if (window <= 64 && $urandom_range(0, 3) == 0) begin
                    push_request(rcrls_pkg::REQ_BEGIN_RD, pins_t'($urandom), chan_t'($urandom),
                                 time_t'($urandom), 1);
                    n = 0;
                end else begin
                    push_side_request(window, 0);
                end
            end
            if (scrambled) begin
                pins = pins_t'($urandom);
            end else begin
                for (int k = 0; k < rcrls_pkg::CHANNELS; k++)
                    pins[k] = (n < drop_at[k]);
                if ($urandom_range(0, 9) == 0)
                    pins[$urandom_range(0, rcrls_pkg::CHANNELS - 1)] ^= 1'b1;
            end
            push_request(rcrls_pkg::REQ_TICK, pins, chan_t'($urandom), time_t'($urandom), 1);
            n++;
        end
    endtask

    task automatic wait_drained;
        while (!(pending_requests.size() == 0 && accepted_items == offered_items
                 && expected_lines.size() == 0))
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_max_wait(input time_t value);
        @(negedge aclk);
        cfg_wdata = value;
        cfg_wvalid = 1'b1;
        do @(posedge aclk); while (!cfg_wready);
        max_wait_reg = value;
        @(negedge aclk);
        cfg_wvalid = 1'b0;
    endtask

    task automatic run_random_phase(input int unsigned window,
                                    input int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        write_max_wait(time_t'(window));
        for (int k = 0; k < rcrls_pkg::CHANNELS; k++)
            push_request(rcrls_pkg::REQ_LOAD_THR, pins_t'($urandom), chan_t'(k),
                         time_t'($urandom_range(0, window)), 1);
        stop_at = stim_count + quota;
        while (stim_count < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                push_reading(window);
            end else if (pick <= 7) begin
                push_request(rcrls_pkg::REQ_BEGIN_CAL, pins_t'($urandom), chan_t'($urandom),
                             time_t'($urandom), 1);
                repeat ($urandom_range(2, 4)) push_reading(window);
                push_request(rcrls_pkg::REQ_END_CAL, pins_t'($urandom), chan_t'($urandom),
                             time_t'($urandom), 1);
            end else begin
                push_side_request(window, 1);
            end
        end
        wait_drained();
    endtask

    initial begin
        max_wait_reg = rcrls_pkg::RESET_WAIT;
        for (int k = 0; k < rcrls_pkg::CHANNELS; k++) begin
            disch_time[k] = '0;
            went_low[k] = 1'b0;
            cal_high[k] = '0;
            cal_low[k] = rcrls_pkg::RESET_WAIT;
            chan_thr[k] = rcrls_pkg::RESET_THRESHOLD;
        end
        tick_count = '0;
        reading_open = 1'b0;
        cal_on = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // idle-state requests at the reset window length
        push_request(rcrls_pkg::REQ_TICK, '0, '0, '0, 0);
        push_request(code_t'(rcrls_pkg::REQ_LOAD_THR + 1), '1, '1, '1, 0);
        push_request(code_t'((1 << rcrls_pkg::REQ_BITS) - 1), '0, '0, '0, 0);
        push_request(rcrls_pkg::REQ_END_CAL, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_LOAD_THR, '0, chan_t'(0), '0, 1);
        push_request(rcrls_pkg::REQ_LOAD_THR, '1, chan_t'(rcrls_pkg::CHANNELS - 1),
                     rcrls_pkg::TIME_MAX, 1);
        push_request(rcrls_pkg::REQ_LOAD_THR, '0, chan_t'(3), time_t'(1), 1);
        push_request(rcrls_pkg::REQ_BEGIN_CAL, '0, '0, '0, 1);
        wait_drained();

        // shortest window: every line low, none low, a restarted reading
        write_max_wait(time_t'(1));
        push_request(rcrls_pkg::REQ_BEGIN_RD, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_TICK, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_BEGIN_RD, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_TICK, '1, '1, '1, 1);
        push_request(rcrls_pkg::REQ_BEGIN_RD, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_BEGIN_RD, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_TICK, pins_t'(8'hA5), '0, '0, 1);
        push_request(rcrls_pkg::REQ_END_CAL, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_BEGIN_RD, '0, '0, '0, 1);
        push_request(rcrls_pkg::REQ_TICK, '1, '0, '0, 1);
        push_request(rcrls_pkg::REQ_TICK, '0, '0, '0, 0);
        wait_drained();

        // long window, calibrated
        write_max_wait(time_t'(300));
        push_request(rcrls_pkg::REQ_BEGIN_CAL, '0, '0, '0, 1);
        push_reading(300);
        push_request(rcrls_pkg::REQ_END_CAL, '0, '0, '0, 1);
        wait_drained();

        stim_count = 0;
        run_random_phase(6, 130);
        run_random_phase(17, 130);
        run_random_phase(2, 130);
        run_random_phase(40, 130);
        run_random_phase(11, 130);
        run_random_phase(25, 130);

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rcrls_pkg.sv
rtl/core/rcrls_lane.sv
rtl/core/rcrls_merge.sv
rtl/core/rc_reflectance_line_sensor_unit.sv
test/rc_reflectance_line_sensor_unit_test.sv
